// ----- src/base64_custom_alphabet_encoder_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the Base64 encoder RTL.
// ---------------------------------------------------------------------------
`ifndef BASE64_CUSTOM_ALPHABET_ENCODER_UNIT_DEFINES_SVH
`define BASE64_CUSTOM_ALPHABET_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define B64E_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("b64e check failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define B64E_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("b64e check failed: next-cycle implication");

`endif

// ----- src/b64e_pkg.sv -----
// ---------------------------------------------------------------------------
// b64e_pkg
// Types, phase codes and the alphabet lookup of the Base64 encoder.
// ---------------------------------------------------------------------------
package b64e_pkg;

    // Position of a byte within its three-byte group.
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;
    localparam logic [1:0] PHASE_3 = 2'd3;

    // The 64-character alphabet; character 0 sits in the top byte.
    localparam logic [8*64-1:0] ALPHABET =
        "WydiArlEV4OMvkDmXpCwj3xa1GIeo9nqHYbT+URcFt8Lf7K25JB/PSQ0ZhzsN6ug";

    // One accepted word together with the group state it saw.
    typedef struct packed {
        logic [1:0] phase;
        logic [5:0] leftover;
        logic [7:0] data;
        logic       last;
    } stage_t;

    // The one or two characters that a word produces.
    typedef struct packed {
        logic [7:0] sym0;
        logic [7:0] sym1;
        logic       last1;
        logic       two;
    } pair_t;

    // Maps a 6-bit group to the ASCII code of its character.
    function automatic logic [7:0] alpha_char(input logic [5:0] idx);
        logic [8:0] base;
        base = {~idx, 3'b000};
        return ALPHABET[base +: 8];
    endfunction

endpackage

// ----- src/b64e_split.sv -----
// ---------------------------------------------------------------------------
// b64e_split
// Splits one registered word into its 6-bit groups and maps them to
// characters.
// ---------------------------------------------------------------------------
module b64e_split (
    input  b64e_pkg::stage_t stage,
    output b64e_pkg::pair_t  pair
);

    logic [5:0] idx0;
    logic [5:0] idx1;

    // Select the bits of each character from the group phase.
    always_comb begin
        unique case (stage.phase)
            b64e_pkg::PHASE_1: begin
                idx0 = stage.leftover | {2'b00, stage.data[7:4]};
                idx1 = {stage.data[3:0], 2'b00};
            end
            b64e_pkg::PHASE_2: begin
                idx0 = stage.leftover | {4'b0000, stage.data[7:6]};
                idx1 = stage.data[5:0];
            end
            b64e_pkg::PHASE_0, b64e_pkg::PHASE_3: begin
                idx0 = stage.data[7:2];
                idx1 = {stage.data[1:0], 4'b0000};
            end
            default: begin
                idx0 = stage.data[7:2];
                idx1 = {stage.data[1:0], 4'b0000};
            end
        endcase
    end

    // The third byte and a last byte give two characters; any other byte gives one.
    assign pair.sym0  = b64e_pkg::alpha_char(idx0);
    assign pair.sym1  = b64e_pkg::alpha_char(idx1);
    assign pair.last1 = stage.last;
    assign pair.two   = stage.last || (stage.phase == b64e_pkg::PHASE_2);

endmodule

// ----- src/base64_custom_alphabet_encoder_unit.sv -----
// ---------------------------------------------------------------------------
// base64_custom_alphabet_encoder_unit: Base64 encoder, fixed alphabet, no pad.
// First character passes the input register, then the output register.
// Throughput: one word per cycle, less under m_ready stalls or two-char words.
// Reset: synchronous active-low aresetn empties both stages, clears the phase.
// ---------------------------------------------------------------------------
`include "base64_custom_alphabet_encoder_unit_defines.svh"

module base64_custom_alphabet_encoder_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_symbol,
    output logic       m_last_symbol
);

    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [5:0]       leftover_reg;
    logic [5:0]       leftover_next;
    logic             in_valid_reg;
    b64e_pkg::stage_t in_reg;
    b64e_pkg::pair_t  pair;
    logic             out_valid_reg;
    logic [7:0]       out_sym_reg;
    logic             out_last_reg;
    logic             pend_valid_reg;
    logic [7:0]       pend_sym_reg;
    logic             pend_last_reg;
    logic             out_free;
    logic             load_out;
    logic             s_take;

    // Handshake: the output stage frees when its last character leaves.
    assign out_free = !out_valid_reg || (m_ready && !pend_valid_reg);
    assign load_out = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || load_out;
    assign s_take   = s_valid && s_ready;

    // Group state after the word being accepted.
    always_comb begin
        unique case (phase_reg)
            b64e_pkg::PHASE_1: begin
                phase_next    = b64e_pkg::PHASE_2;
                leftover_next = {s_data_byte[3:0], 2'b00};
            end
            b64e_pkg::PHASE_2: begin
                phase_next    = b64e_pkg::PHASE_0;
                leftover_next = 6'd0;
            end
            b64e_pkg::PHASE_0, b64e_pkg::PHASE_3: begin
                phase_next    = b64e_pkg::PHASE_1;
                leftover_next = {s_data_byte[1:0], 4'b0000};
            end
            default: begin
                phase_next    = b64e_pkg::PHASE_1;
                leftover_next = {s_data_byte[1:0], 4'b0000};
            end
        endcase
        if (s_is_last) begin
            phase_next    = b64e_pkg::PHASE_0;
            leftover_next = 6'd0;
        end
    end

    // Group state and input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= b64e_pkg::PHASE_0;
            leftover_reg <= 6'd0;
            in_valid_reg <= 1'b0;
        end else begin
            if (s_take) begin
                phase_reg      <= phase_next;
                leftover_reg   <= leftover_next;
                in_valid_reg   <= 1'b1;
                in_reg.phase    <= phase_reg;
                in_reg.leftover <= leftover_reg;
                in_reg.data     <= s_data_byte;
                in_reg.last     <= s_is_last;
            end else if (load_out) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    b64e_split u_split (
        .stage (in_reg),
        .pair  (pair)
    );

    // Output register with one pending character behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                out_valid_reg  <= 1'b1;
                out_sym_reg    <= pair.sym0;
                out_last_reg   <= 1'b0;
                pend_valid_reg <= pair.two;
                pend_sym_reg   <= pair.sym1;
                pend_last_reg  <= pair.last1;
            end else if (out_valid_reg && m_ready) begin
                if (pend_valid_reg) begin
                    out_sym_reg    <= pend_sym_reg;
                    out_last_reg   <= pend_last_reg;
                    pend_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_symbol      = out_sym_reg;
    assign m_last_symbol = out_last_reg;

    // A pending character always sits behind a valid output.
    `B64E_ASSERT_NOW(a_pend_behind_out, aclk, aresetn, pend_valid_reg, out_valid_reg)
    // The final character of a message is never followed by a pending one.
    `B64E_ASSERT_NOW(a_last_alone, aclk, aresetn, m_valid && m_last_symbol, !pend_valid_reg)
    // Popping the first of two characters leaves the second on the port.
    `B64E_ASSERT_NEXT(a_pend_moves, aclk, aresetn,
        out_valid_reg && m_ready && pend_valid_reg, out_valid_reg)
    // A last word returns the group state to its start.
    `B64E_ASSERT_NEXT(a_last_resets_group, aclk, aresetn, s_take && s_is_last,
        (phase_reg == b64e_pkg::PHASE_0) && (leftover_reg == 6'd0))

endmodule
